// ===== hdl/wvct_pkg.sv =====
// ----------------------------------------------------------------------------
// wvct_pkg
// types and constants shared by the watched value change tracker
// ----------------------------------------------------------------------------
package wvct_pkg;

   localparam int unsigned SLOT_W   = 3;
   localparam int unsigned VALUE_W  = 16;
   localparam int unsigned FRAME_W  = 32;
   localparam int unsigned MODE_W   = 3;
   localparam int unsigned RESULT_W = 32;
   localparam int unsigned SIU_W    = 4;

   // width used to compare a slot index against the slot count
   localparam int unsigned SLOT_CMP_W = 9;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [MODE_W-1:0] MODE_CAPTURE       = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PREVIOUS      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CHANGE_FRAME  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CHANGE_COUNT  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_EARLIER_FRAME = 3'd4;

   localparam logic [VALUE_W-1:0] MASK_ALL = 16'hffff;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = 1;
   localparam int unsigned QUEUE_CNT_W = 2;

   // item after classification by the front end
   typedef struct packed {
      logic                is_load;
      logic                unused;
      logic                wr_en;
      logic [SLOT_W-1:0]   slot;
      logic [VALUE_W-1:0]  raw_value;
      logic [FRAME_W-1:0]  frame_number;
      logic [MODE_W-1:0]   mode;
      logic [VALUE_W-1:0]  mask;
      logic [VALUE_W-1:0]  match_value;
   } cls_item_type;

   // one watch slot: descriptor and tracking state
   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [VALUE_W-1:0]  mask;
      logic [VALUE_W-1:0]  match_value;
      logic [VALUE_W-1:0]  latest;
      logic [VALUE_W-1:0]  older;
      logic [VALUE_W-1:0]  last_seen;
      logic [FRAME_W-1:0]  change_frame;
      logic [FRAME_W-1:0]  earlier_frame;
      logic [RESULT_W-1:0] change_count;
   } slot_entry_type;

   localparam slot_entry_type ENTRY_RESET = '{
      mode:          MODE_CAPTURE,
      mask:          MASK_ALL,
      match_value:   '0,
      latest:        '0,
      older:         '0,
      last_seen:     '0,
      change_frame:  '0,
      earlier_frame: '0,
      change_count:  '0
   };

endpackage

// ===== hdl/wvct_front.sv =====
// ----------------------------------------------------------------------------
// wvct_front
// holds the slot count register, classifies items and pushes them on
// ----------------------------------------------------------------------------
module wvct_front import wvct_pkg::*; #(
   parameter int unsigned SLOTS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [SIU_W-1:0]    csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [VALUE_W-1:0]  req_raw_value,
   input  logic [FRAME_W-1:0]  req_frame_number,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [VALUE_W-1:0]  req_mask,
   input  logic [VALUE_W-1:0]  req_match_value,
   input  logic                queue_full,
   output logic                push_valid,
   output cls_item_type        push_item
);

   localparam logic [SLOT_CMP_W-1:0] SLOTS_LIM = SLOT_CMP_W'(SLOTS);

   logic [SIU_W-1:0]      slots_in_use_ff;
   logic [SIU_W-1:0]      slots_in_use_in;
   logic [SLOT_CMP_W-1:0] slot_ext;
   logic                  in_range;
   logic                  slot_used;

   assign slots_in_use_in = csr_wr_en ? csr_wr_data : slots_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_in_use_ff <= '0;
      end else begin
         slots_in_use_ff <= slots_in_use_in;
      end
   end

   // a count above the table size acts as the table size
   assign slot_ext  = SLOT_CMP_W'(req_slot);
   assign in_range  = slot_ext < SLOTS_LIM;
   assign slot_used = in_range && ({1'b0, req_slot} < slots_in_use_ff);

   always_comb begin
      push_item              = '0;
      push_item.is_load      = (req_cmd == CMD_LOAD);
      push_item.unused       = !slot_used;
      push_item.wr_en        = (req_cmd == CMD_LOAD) ? in_range : slot_used;
      push_item.slot         = req_slot;
      push_item.raw_value    = req_raw_value;
      push_item.frame_number = req_frame_number;
      push_item.mode         = req_mode;
      push_item.mask         = (req_mask == '0) ? MASK_ALL : req_mask;
      push_item.match_value  = req_match_value;
   end

   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full;

endmodule

// ===== hdl/wvct_queue.sv =====
// ----------------------------------------------------------------------------
// wvct_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
module wvct_queue import wvct_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  cls_item_type push_item,
   output logic         full,
   output logic         pop_valid,
   output cls_item_type pop_item,
   input  logic         pop
);

   cls_item_type           entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && !pop |-> !push_valid)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue read while empty");

endmodule

// ===== hdl/wvct_back.sv =====
// ----------------------------------------------------------------------------
// wvct_back
// slot memory read, update and write back, and the result register
// ----------------------------------------------------------------------------
module wvct_back import wvct_pkg::*; #(
   parameter int unsigned SLOTS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  cls_item_type        pop_item,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [RESULT_W-1:0] rsp_value,
   output logic                rsp_slot_unused
);

   localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } back_state_type;

   back_state_type        state_ff;
   back_state_type        state_in;

   slot_entry_type        slot_mem_ff [SLOTS];
   logic [SLOTS-1:0]      valid_ff;
   slot_entry_type        rd_entry_ff;
   logic                  rd_valid_ff;
   cls_item_type          cur_ff;

   logic [SLOT_CMP_W-1:0] pop_slot_ext;
   logic [SLOT_CMP_W-1:0] cur_slot_ext;
   logic [IDX_W-1:0]      pop_idx;
   logic [IDX_W-1:0]      cur_idx;
   logic                  exec;

   slot_entry_type        old_entry;
   slot_entry_type        new_entry;
   logic [VALUE_W-1:0]    filt;
   logic                  changed;
   logic [RESULT_W-1:0]   result;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RESULT_W-1:0]   rsp_value_ff;
   logic                  rsp_unused_ff;

   assign pop_slot_ext = SLOT_CMP_W'(pop_item.slot);
   assign cur_slot_ext = SLOT_CMP_W'(cur_ff.slot);
   assign pop_idx      = pop_slot_ext[IDX_W-1:0];
   assign cur_idx      = cur_slot_ext[IDX_W-1:0];
   assign exec         = (state_ff == ST_EXEC);

   // take an item only when the result register will be free for it
   assign pop = pop_valid && (state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // registered memory read, issued as the item leaves the queue
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff      <= pop_item;
         rd_entry_ff <= slot_mem_ff[pop_idx];
         rd_valid_ff <= valid_ff[pop_idx];
      end
   end

   // never written entries read as the reset descriptor
   assign old_entry = rd_valid_ff ? rd_entry_ff : ENTRY_RESET;

   always_comb begin
      new_entry = old_entry;
      result    = '0;
      filt      = cur_ff.raw_value & old_entry.mask;
      if (old_entry.match_value != '0 && filt != old_entry.match_value) begin
         filt = '0;
      end
      changed = (old_entry.last_seen != filt);
      if (cur_ff.is_load) begin
         new_entry             = ENTRY_RESET;
         new_entry.mode        = cur_ff.mode;
         new_entry.mask        = cur_ff.mask;
         new_entry.match_value = cur_ff.match_value;
      end else if (!cur_ff.unused) begin
         case (old_entry.mode)
            MODE_CAPTURE: begin
               result = RESULT_W'(filt);
            end
            MODE_PREVIOUS: begin
               if (old_entry.latest != filt) begin
                  new_entry.older  = old_entry.latest;
                  new_entry.latest = filt;
               end
               result = RESULT_W'(new_entry.older);
            end
            MODE_CHANGE_FRAME: begin
               if (changed) begin
                  new_entry.last_seen    = filt;
                  new_entry.change_frame = cur_ff.frame_number;
               end
               result = new_entry.change_frame;
            end
            MODE_CHANGE_COUNT: begin
               if (changed) begin
                  new_entry.last_seen    = filt;
                  new_entry.change_count = old_entry.change_count + 1'b1;
               end
               result = new_entry.change_count;
            end
            MODE_EARLIER_FRAME: begin
               if (changed) begin
                  new_entry.last_seen     = filt;
                  new_entry.earlier_frame = old_entry.change_frame;
                  new_entry.change_frame  = cur_ff.frame_number;
               end
               result = new_entry.earlier_frame;
            end
            default: begin
               result = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (exec && cur_ff.wr_en) begin
         slot_mem_ff[cur_idx] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (exec && cur_ff.wr_en) begin
         valid_ff[cur_idx] <= 1'b1;
      end
   end

   // result register
   assign rsp_valid_in = exec || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_value_ff  <= result;
         rsp_unused_ff <= cur_ff.unused;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_slot_unused = rsp_unused_ff;

   a_exec_has_room: assert property (@(posedge clock) disable iff (reset)
      exec |-> !rsp_valid_ff || !rsp_stall || !$past(rsp_valid_ff))
      else $error("result register busy when an item completes");

   a_load_gives_zero: assert property (@(posedge clock) disable iff (reset)
      exec && cur_ff.is_load |=> rsp_valid_ff && rsp_value_ff == '0)
      else $error("load item returned a nonzero value");

endmodule

// ===== hdl/watched_value_change_tracker_core.sv =====
// ----------------------------------------------------------------------------
// watched_value_change_tracker_core
// table of watch slots that follow sampled values from frame to frame
// ----------------------------------------------------------------------------
// usage
//   req_ channel: one item per handshake, cmd selects load (slot descriptor:
//   mode, mask, match value; tracking state cleared) or sample (raw value
//   and frame number of this frame)
//   rsp_ channel: exactly one item per request, in order: tracked value and
//   the slot unused flag; a load answers value 0
//   csr_ port: slots_in_use, written with csr_wr_en while the block is idle
//   a request passes through the queue, the registered slot read and the
//   result register; a new item is taken from the queue only once the last
//   is written back to the slot memory (one port pair, registered read)
//   a two entry queue separates the front end from the slot engine, so
//   requests are still taken while a result waits on rsp_stall
//   reset: slots_in_use goes to 0 and every slot reads as the reset
//   descriptor (capture mode, all ones mask) through per slot valid bits,
//   so no clearing pass is needed
//   a held result stays stable on rsp_stall; the queue then fills and
//   req_stall is raised
// ----------------------------------------------------------------------------
module watched_value_change_tracker_core import wvct_pkg::*; #(
   parameter int unsigned SLOTS = 8
) (
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_wr_en,
   input  logic [SIU_W-1:0]    csr_wr_data,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [VALUE_W-1:0]  req_raw_value,
   input  logic [FRAME_W-1:0]  req_frame_number,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [VALUE_W-1:0]  req_mask,
   input  logic [VALUE_W-1:0]  req_match_value,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [RESULT_W-1:0] rsp_value,
   output logic                rsp_slot_unused
);

   // front end to queue
   logic         push_valid;
   cls_item_type push_item;
   logic         queue_full;

   // queue to slot engine
   logic         pop_valid;
   cls_item_type pop_item;
   logic         pop;

   // classification: slot range, unused flag, mask normalisation
   wvct_front #(
      .SLOTS (SLOTS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_slot         (req_slot),
      .req_raw_value    (req_raw_value),
      .req_frame_number (req_frame_number),
      .req_mode         (req_mode),
      .req_mask         (req_mask),
      .req_match_value  (req_match_value),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_item        (push_item)
   );

   // decoupling queue
   wvct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop        (pop)
   );

   // slot engine: memory read, update, write back and result register
   wvct_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_item        (pop_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_slot_unused (rsp_slot_unused)
   );

endmodule

// ===== verif/watched_value_change_tracker_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// watched_value_change_tracker_core_tb
// self-checking bench: a queue-fed driver offers load and sample items, a
// shadow of the slot table works out each answer at acceptance, and a monitor
// compares every returned item in order against those answers
// ----------------------------------------------------------------------------
module watched_value_change_tracker_core_tb;
   import wvct_pkg::*;

   localparam int unsigned SLOTS       = 8;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_CYCLES = 300;

   typedef struct {
      logic                cmd;
      logic [SLOT_W-1:0]   slot;
      logic [VALUE_W-1:0]  raw_value;
      logic [FRAME_W-1:0]  frame_number;
      logic [MODE_W-1:0]   mode;
      logic [VALUE_W-1:0]  mask;
      logic [VALUE_W-1:0]  match_value;
   } watch_item_type;

   typedef struct {
      logic [RESULT_W-1:0] value;
      logic                slot_unused;
   } slot_answer_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #1 clock = ~clock;

   // block inputs, all known from time zero
   logic                csr_wr_en        = 1'b0;
   logic [SIU_W-1:0]    csr_wr_data      = '0;
   logic                req_valid        = 1'b0;
   logic                req_cmd          = CMD_LOAD;
   logic [SLOT_W-1:0]   req_slot         = '0;
   logic [VALUE_W-1:0]  req_raw_value    = '0;
   logic [FRAME_W-1:0]  req_frame_number = '0;
   logic [MODE_W-1:0]   req_mode         = MODE_CAPTURE;
   logic [VALUE_W-1:0]  req_mask         = '0;
   logic [VALUE_W-1:0]  req_match_value  = '0;
   logic                rsp_stall        = 1'b0;

   // block outputs
   logic                req_stall;
   logic                rsp_valid;
   logic [RESULT_W-1:0] rsp_value;
   logic                rsp_slot_unused;

   watched_value_change_tracker_core #(
      .SLOTS(SLOTS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_slot         (req_slot),
      .req_raw_value    (req_raw_value),
      .req_frame_number (req_frame_number),
      .req_mode         (req_mode),
      .req_mask         (req_mask),
      .req_match_value  (req_match_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_slot_unused  (rsp_slot_unused)
   );

   // items waiting to be offered, answers waiting to come back
   watch_item_type  items_to_send[$];
   slot_answer_type answers_due[$];
   watch_item_type  on_offer;

   int unsigned mismatches  = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap    = 0;
   int unsigned stall_left  = 0;
   logic        quiet        = 1'b0;  // no idling on either side
   logic        hold_request = 1'b0;
   logic        long_hold    = 1'b0;
   logic [FRAME_W-1:0] frame_now = '0;

   // shadow of the configuration and of the slot table
   logic [SIU_W-1:0]    active_shadow;
   logic [MODE_W-1:0]   slot_mode     [SLOTS];
   logic [VALUE_W-1:0]  slot_mask     [SLOTS];
   logic [VALUE_W-1:0]  slot_match    [SLOTS];
   logic [VALUE_W-1:0]  latest_val    [SLOTS];
   logic [VALUE_W-1:0]  older_val     [SLOTS];
   logic [VALUE_W-1:0]  last_seen_val [SLOTS];
   logic [FRAME_W-1:0]  changed_at    [SLOTS];
   logic [FRAME_W-1:0]  changed_before[SLOTS];
   logic [RESULT_W-1:0] change_total  [SLOTS];

   function automatic void clear_slot_tracking(int unsigned s);
      latest_val[s]     = '0;
      older_val[s]      = '0;
      last_seen_val[s]  = '0;
      changed_at[s]     = '0;
      changed_before[s] = '0;
      change_total[s]   = '0;
   endfunction

   // applies one item to the shadow table and returns the answer it gives
   function automatic slot_answer_type track_item(watch_item_type it);
      slot_answer_type    ans;
      int unsigned        active;
      int unsigned        s;
      logic [VALUE_W-1:0] v;
      logic               changed;
      s          = 32'(it.slot);
      active     = (active_shadow < SLOTS) ? 32'(active_shadow) : SLOTS;
      ans.value  = '0;
      ans.slot_unused = (s >= active);
      if (it.cmd == CMD_LOAD) begin
         // descriptor is written whatever the active count says
         if (s < SLOTS) begin
            slot_mode[s]  = it.mode;
            slot_mask[s]  = (it.mask == '0) ? MASK_ALL : it.mask;
            slot_match[s] = it.match_value;
            clear_slot_tracking(s);
         end
      end else if (!ans.slot_unused) begin
         v = it.raw_value & slot_mask[s];
         if (slot_match[s] != '0 && v != slot_match[s])
            v = '0;
         changed = (last_seen_val[s] != v);
         case (slot_mode[s])
            MODE_CAPTURE: begin
               ans.value = RESULT_W'(v);
            end
            MODE_PREVIOUS: begin
               if (latest_val[s] != v) begin
                  older_val[s]  = latest_val[s];
                  latest_val[s] = v;
               end
               ans.value = RESULT_W'(older_val[s]);
            end
            MODE_CHANGE_FRAME: begin
               if (changed) begin
                  last_seen_val[s] = v;
                  changed_at[s]    = it.frame_number;
               end
               ans.value = changed_at[s];
            end
            MODE_CHANGE_COUNT: begin
               if (changed) begin
                  last_seen_val[s] = v;
                  change_total[s]  = change_total[s] + 1'b1;
               end
               ans.value = change_total[s];
            end
            MODE_EARLIER_FRAME: begin
               if (changed) begin
                  last_seen_val[s]  = v;
                  changed_before[s] = changed_at[s];
                  changed_at[s]     = it.frame_number;
               end
               ans.value = changed_before[s];
            end
            // modes five to seven answer zero and leave the slot alone
            default: ans.value = '0;
         endcase
      end
      return ans;
   endfunction

   function automatic watch_item_type load_item(int unsigned s, int unsigned md,
                                                int unsigned msk, int unsigned mt);
      watch_item_type it;
      it.cmd          = CMD_LOAD;
      it.slot         = SLOT_W'(s);
      it.raw_value    = VALUE_W'($urandom());
      it.frame_number = $urandom();
      it.mode         = MODE_W'(md);
      it.mask         = VALUE_W'(msk);
      it.match_value  = VALUE_W'(mt);
      return it;
   endfunction

   function automatic watch_item_type sample_item(int unsigned s, int unsigned raw,
                                                  int unsigned frm);
      watch_item_type it;
      it.cmd          = CMD_SAMPLE;
      it.slot         = SLOT_W'(s);
      it.raw_value    = VALUE_W'(raw);
      it.frame_number = frm;
      it.mode         = MODE_W'($urandom());
      it.mask         = VALUE_W'($urandom());
      it.match_value  = VALUE_W'($urandom());
      return it;
   endfunction

   // ---------------------------------------------------------------------
   // driver: offers queued items, holds the payload while stalled and
   // works out the answer on the edge where an item is taken
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : req_side
      logic offering;
      offering = req_valid;
      if (reset) begin
         offering = 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            answers_due.push_back(track_item(on_offer));
            offering = 1'b0;
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (items_to_send.size() != 0) begin
               if (!quiet && $urandom_range(0, 7) == 0) begin
                  send_gap = $urandom_range(1, 13);
               end else begin
                  on_offer         = items_to_send.pop_front();
                  offering         = 1'b1;
                  req_cmd          <= on_offer.cmd;
                  req_slot         <= on_offer.slot;
                  req_raw_value    <= on_offer.raw_value;
                  req_frame_number <= on_offer.frame_number;
                  req_mode         <= on_offer.mode;
                  req_mask         <= on_offer.mask;
                  req_match_value  <= on_offer.match_value;
               end
            end
         end
      end
      // one assignment per edge, so a back-to-back offer stays high
      req_valid <= offering;
   end

   // ---------------------------------------------------------------------
   // monitor: checks each returned item against the oldest answer due and
   // stalls in random bursts, or for the whole long hold-off
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_side
      slot_answer_type due;
      if (reset) begin
         stall_left = 0;
         rsp_stall  <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $error("result with no item outstanding: value %0h slot_unused %0b",
                      rsp_value, rsp_slot_unused);
               mismatches++;
            end else begin
               due = answers_due.pop_front();
               if (rsp_value !== due.value) begin
                  $error("value: expected %0h, actual %0h", due.value, rsp_value);
                  mismatches++;
               end
               if (rsp_slot_unused !== due.slot_unused) begin
                  $error("slot_unused: expected %0b, actual %0b",
                         due.slot_unused, rsp_slot_unused);
                  mismatches++;
               end
            end
         end
         if (stall_left > 0)
            stall_left--;
         else if (!quiet && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 13);
         rsp_stall <= long_hold || (stall_left > 0);
      end
   end

   // long receiver hold-off so the internal queue fills and req_stall rises
   initial begin : hold_off
      wait (hold_request);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("watched_value_change_tracker_core_tb: FAIL");
         $finish;
      end
   end

   // block is idle once nothing is queued, offered or outstanding; looked
   // at between edges so that an offer made on the last edge is seen
   task automatic wait_drained();
      @(negedge clock);
      while (items_to_send.size() != 0 || req_valid || answers_due.size() != 0)
         @(negedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_active_slots(int unsigned n);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= SIU_W'(n);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      active_shadow = SIU_W'(n);
   endtask

   // mostly load-then-sample runs over a small value alphabet so that
   // repeats and changes both happen, with some fully random noise
   task automatic queue_random_items(int unsigned n);
      watch_item_type it;
      int unsigned pick;
      int unsigned md;
      int unsigned msk;
      int unsigned mt;
      int unsigned raw;
      for (int unsigned i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            it.cmd          = 1'($urandom());
            it.slot         = SLOT_W'($urandom());
            it.raw_value    = VALUE_W'($urandom());
            it.frame_number = $urandom();
            it.mode         = MODE_W'($urandom());
            it.mask         = VALUE_W'($urandom());
            it.match_value  = VALUE_W'($urandom());
         end else if (pick < 28) begin
            md = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 4)
                                             : $urandom_range(5, 7);
            case ($urandom_range(0, 3))
               0:       msk = 0;
               1:       msk = 32'(MASK_ALL);
               2:       msk = 16'h000f;
               default: msk = $urandom();
            endcase
            case ($urandom_range(0, 9))
               0, 1:    mt = $urandom_range(1, 3);
               2:       mt = $urandom();
               default: mt = 0;
            endcase
            it = load_item($urandom_range(0, SLOTS - 1), md, msk, mt);
         end else begin
            case ($urandom_range(0, 9))
               0, 1:    raw = $urandom();
               2:       raw = ($urandom_range(0, 255) << 8) | $urandom_range(0, 3);
               default: raw = $urandom_range(0, 3);
            endcase
            if ($urandom_range(0, 9) == 0)
               frame_now = $urandom();
            else
               frame_now = frame_now + $urandom_range(0, 2);
            it = sample_item($urandom_range(0, SLOTS - 1), raw, frame_now);
         end
         items_to_send.push_back(it);
      end
   endtask

   // ---------------------------------------------------------------------
   // stimulus sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      active_shadow = '0;
      for (int unsigned s = 0; s < SLOTS; s++) begin
         slot_mode[s]  = MODE_CAPTURE;
         slot_mask[s]  = MASK_ALL;
         slot_match[s] = '0;
         clear_slot_tracking(s);
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // out of reset no slot is active, yet a load still lands
      items_to_send.push_back(sample_item(0, 16'hffff, 32'hffff_ffff));
      items_to_send.push_back(load_item(7, MODE_CHANGE_COUNT, 0, 0));
      wait_drained();
      write_active_slots(SLOTS);

      // directed: every mode, mask of zero, match filter, frame extremes
      items_to_send.push_back(sample_item(7, 1, 10));
      items_to_send.push_back(sample_item(7, 1, 11));
      items_to_send.push_back(sample_item(7, 0, 12));
      items_to_send.push_back(sample_item(0, 16'hffff, 13));
      items_to_send.push_back(load_item(1, MODE_PREVIOUS, 16'hffff, 0));
      items_to_send.push_back(sample_item(1, 5, 14));
      items_to_send.push_back(sample_item(1, 5, 15));
      items_to_send.push_back(sample_item(1, 9, 16));
      items_to_send.push_back(load_item(2, MODE_CHANGE_FRAME, 16'h00ff, 0));
      items_to_send.push_back(sample_item(2, 16'h1234, 32'hffff_ffff));
      items_to_send.push_back(sample_item(2, 16'hab34, 32'h0000_0000));
      items_to_send.push_back(load_item(3, MODE_EARLIER_FRAME, 0, 16'h0f0f));
      items_to_send.push_back(sample_item(3, 16'h0f0f, 100));
      items_to_send.push_back(sample_item(3, 16'h0f0e, 200));
      items_to_send.push_back(sample_item(3, 16'h0f0f, 300));
      items_to_send.push_back(load_item(4, 5, 16'h1234, 0));
      items_to_send.push_back(sample_item(4, 16'hffff, 400));
      items_to_send.push_back(load_item(5, 7, 0, 16'hffff));
      items_to_send.push_back(sample_item(5, 16'hffff, 500));
      items_to_send.push_back(load_item(6, 6, 16'h8000, 16'h8000));
      items_to_send.push_back(sample_item(6, 16'h8000, 600));
      items_to_send.push_back(load_item(0, MODE_CAPTURE, 16'h8001, 16'h8001));
      items_to_send.push_back(sample_item(0, 16'hffff, 700));
      items_to_send.push_back(sample_item(0, 16'h8000, 701));
      frame_now = 1000;
      wait_drained();

      // random phases over several active counts, the first under a long
      // receiver hold-off while items keep coming
      hold_request <= 1'b1;
      queue_random_items(100);
      wait_drained();
      write_active_slots(15);   // above the table size, acts as all slots
      queue_random_items(100);
      wait_drained();
      write_active_slots(1);
      queue_random_items(80);
      wait_drained();
      write_active_slots(0);
      queue_random_items(20);
      wait_drained();
      write_active_slots(5);
      queue_random_items(100);
      wait_drained();
      write_active_slots(7);
      queue_random_items(100);
      wait_drained();

      // closing stretch at full rate on both sides
      write_active_slots(SLOTS);
      quiet <= 1'b1;
      queue_random_items(120);
      wait_drained();
      repeat (8) @(posedge clock);

      if (mismatches == 0)
         $display("watched_value_change_tracker_core_tb: PASS");
      else
         $display("watched_value_change_tracker_core_tb: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/wvct_pkg.sv
hdl/wvct_front.sv
hdl/wvct_queue.sv
hdl/wvct_back.sv
hdl/watched_value_change_tracker_core.sv
verif/watched_value_change_tracker_core_tb.sv
